FILE: design/y2r_pkg.sv
// Types, constants and helper functions for the YUYV to RGB pixel-pair converter.
// Depends on nothing; every module of the converter imports it.
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

  // Width of one chroma product and of one channel sum (Q16 fixed point)
  localparam int PROD_W = 25;
  localparam int SUM_W  = 26;
  localparam int FRAC_W = 16;

  // Q16 coefficients
  localparam logic signed [PROD_W-1:0] COEF_R_V = 25'sd89831;
  localparam logic signed [PROD_W-1:0] COEF_G_V = 25'sd45744;
  localparam logic signed [PROD_W-1:0] COEF_G_U = 25'sd22127;
  localparam logic signed [PROD_W-1:0] COEF_B_U = 25'sd113538;

  // Output scale 220/256
  localparam logic [15:0] SCALE_NUM = 16'd220;
  localparam logic [7:0]  CHAN_MAX  = 8'd219;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end;
  } yuyv_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;
  } rgb_out_t;

  // Stage 1 result: both lumas and the four shared chroma products
  typedef struct packed {
    logic [7:0]               luma_first;
    logic [7:0]               luma_second;
    logic signed [PROD_W-1:0] r_v;
    logic signed [PROD_W-1:0] g_v;
    logic signed [PROD_W-1:0] g_u;
    logic signed [PROD_W-1:0] b_u;
    logic                     frame_end;
  } prod_t;

  // Stage 2 result: six channels clamped to 0..255
  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end;
  } clamp_t;

  // Remove the 128 offset: u - 128 as an 8-bit signed value, sign-extended
  function automatic logic signed [PROD_W-1:0] chroma_delta(input logic [7:0] c);
    logic [7:0] d;
    d = {~c[7], c[6:0]};
    return {{(PROD_W-8){d[7]}}, d};
  endfunction

  // Widen a product to sum width
  function automatic logic signed [SUM_W-1:0] widen(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // Luma placed at Q16
  function automatic logic signed [SUM_W-1:0] luma_q16(input logic [7:0] y);
    return {{(SUM_W-FRAC_W-8){1'b0}}, y, {FRAC_W{1'b0}}};
  endfunction

  // Floor the Q16 sum to an integer and clamp to 0..255
  function automatic logic [7:0] floor_clamp(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-FRAC_W-1:0] whole;
    logic [7:0]              res;
    whole = s[SUM_W-1:FRAC_W];
    if (whole[SUM_W-FRAC_W-1]) begin
      res = 8'd0;
    end else if (|whole[SUM_W-FRAC_W-2:8]) begin
      res = 8'd255;
    end else begin
      res = whole[7:0];
    end
    return res;
  endfunction

  // Scale by 220/256 with floor
  function automatic logic [7:0] scale_chan(input logic [7:0] c);
    logic [15:0] p;
    p = {8'd0, c} * SCALE_NUM;
    return p[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: design/yuyv_to_rgb_pixel_pair.sv
// Top level of the YUYV 4:2:2 to RGB pixel-pair converter: three-stage pipeline.
// Depends on y2r_pkg, y2r_chroma_mult, y2r_sum_clamp and y2r_scale.
//
//   channel  direction  payload     handshake
//   in_*     input      yuyv_in_t   in_valid / in_stall
//   out_*    output     rgb_out_t   out_valid / out_stall
//
// One group per cycle is taken while in_stall is low; a result passes through the
// product, sum/clamp and scale registers in that order before it leaves.
// Reset clears the three stage valid bits; payload registers are not reset.
// A stall on the output holds only the full stages: an empty stage keeps filling,
// so in_stall rises only when all three stages hold data and out_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_rgb_pixel_pair
  import y2r_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire yuyv_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output rgb_out_t      out_data
);

  logic   s1_valid;
  logic   s1_stall;
  prod_t  s1_data;
  logic   s2_valid;
  logic   s2_stall;
  clamp_t s2_data;

  y2r_chroma_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_stall (s1_stall),
    .dn_data  (s1_data)
  );

  y2r_sum_clamp u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_stall (s1_stall),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_stall (s2_stall),
    .dn_data  (s2_data)
  );

  y2r_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_stall (s2_stall),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

  // Input backs up only with the whole pipeline full and the output stalled
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
    else $error("input stalled while a pipeline stage is free");

  // Reset empties the output stage
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Scaled channels never exceed 219
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red_first <= CHAN_MAX && out_data.green_first <= CHAN_MAX &&
                   out_data.blue_first <= CHAN_MAX && out_data.red_second <= CHAN_MAX &&
                   out_data.green_second <= CHAN_MAX && out_data.blue_second <= CHAN_MAX))
    else $error("scaled channel out of range");

  // A full stage two with a stalled output keeps its item
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && out_valid && out_stall) |=> s2_valid)
    else $error("stage two item lost under stall");

endmodule

`default_nettype wire

FILE: design/y2r_chroma_mult.sv
// Stage 1 of the converter: removes the chroma offset and forms the four chroma products.
// Depends on y2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module y2r_chroma_mult
  import y2r_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     up_valid,
  output logic          up_stall,
  input  wire yuyv_in_t up_data,
  output logic          dn_valid,
  input  wire logic     dn_stall,
  output prod_t         dn_data
);

  logic                     valid_r;
  logic                     advance;
  prod_t                    data_r;
  prod_t                    data_nxt;
  logic signed [PROD_W-1:0] du;
  logic signed [PROD_W-1:0] dv;

  // Advance when the stage is empty or its content moves on
  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  // Form the shared products
  always_comb begin
    du = chroma_delta(up_data.chroma_blue);
    dv = chroma_delta(up_data.chroma_red);
    data_nxt.luma_first  = up_data.luma_first;
    data_nxt.luma_second = up_data.luma_second;
    data_nxt.r_v         = COEF_R_V * dv;
    data_nxt.g_v         = COEF_G_V * dv;
    data_nxt.g_u         = COEF_G_U * du;
    data_nxt.b_u         = COEF_B_U * du;
    data_nxt.frame_end   = up_data.frame_end;
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  // Payload, loaded on transfer only
  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

FILE: design/y2r_sum_clamp.sv
// Stage 2 of the converter: adds luma to the chroma products, floors and clamps each channel.
// Depends on y2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module y2r_sum_clamp
  import y2r_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_stall,
  input  wire prod_t up_data,
  output logic       dn_valid,
  input  wire logic  dn_stall,
  output clamp_t     dn_data
);

  logic                    valid_r;
  logic                    advance;
  clamp_t                  data_r;
  clamp_t                  data_nxt;
  logic signed [SUM_W-1:0] base0;
  logic signed [SUM_W-1:0] base1;
  logic signed [SUM_W-1:0] r_v;
  logic signed [SUM_W-1:0] g_uv;
  logic signed [SUM_W-1:0] b_u;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  // Sum, floor and clamp both pixels
  always_comb begin
    base0 = luma_q16(up_data.luma_first);
    base1 = luma_q16(up_data.luma_second);
    r_v   = widen(up_data.r_v);
    g_uv  = widen(up_data.g_v) + widen(up_data.g_u);
    b_u   = widen(up_data.b_u);
    data_nxt.red_first    = floor_clamp(base0 + r_v);
    data_nxt.green_first  = floor_clamp(base0 - g_uv);
    data_nxt.blue_first   = floor_clamp(base0 + b_u);
    data_nxt.red_second   = floor_clamp(base1 + r_v);
    data_nxt.green_second = floor_clamp(base1 - g_uv);
    data_nxt.blue_second  = floor_clamp(base1 + b_u);
    data_nxt.frame_end    = up_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

FILE: design/y2r_scale.sv
// Stage 3 of the converter: scales each channel by 220/256 into the output register.
// Depends on y2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module y2r_scale
  import y2r_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   up_valid,
  output logic        up_stall,
  input  wire clamp_t up_data,
  output logic        dn_valid,
  input  wire logic   dn_stall,
  output rgb_out_t    dn_data
);

  logic     valid_r;
  logic     advance;
  rgb_out_t data_r;
  rgb_out_t data_nxt;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  // Scale all six channels
  always_comb begin
    data_nxt.red_first     = scale_chan(up_data.red_first);
    data_nxt.green_first   = scale_chan(up_data.green_first);
    data_nxt.blue_first    = scale_chan(up_data.blue_first);
    data_nxt.red_second    = scale_chan(up_data.red_second);
    data_nxt.green_second  = scale_chan(up_data.green_second);
    data_nxt.blue_second   = scale_chan(up_data.blue_second);
    data_nxt.frame_end_out = up_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

FILE: tb/tb_yuyv_to_rgb_pixel_pair.sv
// Self-checking testbench for the YUYV 4:2:2 to RGB pixel-pair converter.
// Depends on y2r_pkg for the payload types and on yuyv_to_rgb_pixel_pair; runs alone.
`timescale 1ns / 1ps

module tb_yuyv_to_rgb_pixel_pair;
  import y2r_pkg::*;

  // Q16 conversion coefficients and output scaling
  localparam int RED_FROM_V   = 89831;
  localparam int GREEN_FROM_V = 45744;
  localparam int GREEN_FROM_U = 22127;
  localparam int BLUE_FROM_U  = 113538;
  localparam int CHROMA_MID   = 128;
  localparam int OUT_SCALE    = 220;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  yuyv_in_t in_data;
  logic     out_valid;
  logic     out_stall;
  rgb_out_t out_data;

  // Expected pixel pairs, oldest first
  rgb_out_t pending_rgb[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_idle_pct  = 0;
  int       hold_requests  = 0;

  yuyv_to_rgb_pixel_pair u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor a Q16 sum, clamp to 0..255, scale by 220/256
  function automatic logic [7:0] scaled_channel(input int q16);
    int level;
    level = q16 >>> 16;
    if (level < 0) begin
      level = 0;
    end else if (level > 255) begin
      level = 255;
    end
    return 8'((level * OUT_SCALE) >> 8);
  endfunction

  // Convert one YUYV group into its two RGB pixels
  function automatic rgb_out_t yuyv_pair_to_rgb(input yuyv_in_t grp);
    int du;
    int dv;
    int y0;
    int y1;
    rgb_out_t rgb;
    du = int'(grp.chroma_blue) - CHROMA_MID;
    dv = int'(grp.chroma_red) - CHROMA_MID;
    y0 = int'(grp.luma_first) << 16;
    y1 = int'(grp.luma_second) << 16;
    rgb.red_first     = scaled_channel(y0 + RED_FROM_V * dv);
    rgb.green_first   = scaled_channel(y0 - GREEN_FROM_V * dv - GREEN_FROM_U * du);
    rgb.blue_first    = scaled_channel(y0 + BLUE_FROM_U * du);
    rgb.red_second    = scaled_channel(y1 + RED_FROM_V * dv);
    rgb.green_second  = scaled_channel(y1 - GREEN_FROM_V * dv - GREEN_FROM_U * du);
    rgb.blue_second   = scaled_channel(y1 + BLUE_FROM_U * du);
    rgb.frame_end_out = grp.frame_end;
    return rgb;
  endfunction

  // Byte biased toward the range ends and the chroma midpoint
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[6];
    corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(3) == 0) begin
      return corners[$urandom_range(5)];
    end
    return 8'($urandom_range(255));
  endfunction

  // Drive one group, idling first at random, and hold it until the transfer
  task automatic send_group(input yuyv_in_t grp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= grp;
    pending_rgb.push_back(yuyv_pair_to_rgb(grp));
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic send_yuyv(input logic [7:0] y0, input logic [7:0] u,
                           input logic [7:0] y1, input logic [7:0] v,
                           input logic fe);
    yuyv_in_t grp;
    grp = {y0, u, y1, v, fe};
    send_group(grp);
  endtask

  task automatic send_random_groups(input int count);
    yuyv_in_t grp;
    repeat (count) begin
      grp.luma_first  = pick_byte();
      grp.chroma_blue = pick_byte();
      grp.luma_second = pick_byte();
      grp.chroma_red  = pick_byte();
      grp.frame_end   = ($urandom_range(15) == 0);
      send_group(grp);
    end
  endtask

  // Drop valid and wait until every expected pixel pair has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic compare_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("mismatch %s at %0t: expected %0d, got %0d", label, $realtime, want, got);
      end
    end
  endtask

  // Range ends, neutral gray, saturated colors and both clamp directions
  task automatic test_directed_extremes();
    send_idle_pct = 34;
    recv_idle_pct = 50;
    send_yuyv(8'd0,   8'd128, 8'd0,   8'd128, 1'b0);
    send_yuyv(8'd255, 8'd128, 8'd255, 8'd128, 1'b1);
    send_yuyv(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_yuyv(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_yuyv(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);
    send_yuyv(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
    send_yuyv(8'd128, 8'd0,   8'd128, 8'd255, 1'b0);
    send_yuyv(8'd128, 8'd255, 8'd128, 8'd0,   1'b0);
    send_yuyv(8'd16,  8'd128, 8'd235, 8'd128, 1'b0);
    send_yuyv(8'd255, 8'd255, 8'd0,   8'd128, 1'b0);
    send_yuyv(8'd0,   8'd0,   8'd255, 8'd0,   1'b1);
    send_yuyv(8'd81,  8'd90,  8'd81,  8'd240, 1'b0);
    send_yuyv(8'd145, 8'd54,  8'd145, 8'd34,  1'b0);
    send_yuyv(8'd41,  8'd240, 8'd41,  8'd110, 1'b0);
    send_yuyv(8'd128, 8'd127, 8'd128, 8'd129, 1'b0);
    send_yuyv(8'd1,   8'd129, 8'd254, 8'd127, 1'b0);
    send_yuyv(8'd200, 8'd64,  8'd50,  8'd192, 1'b1);
  endtask

  task automatic test_sender_bursty();
    send_idle_pct = 34;
    recv_idle_pct = 50;
    send_random_groups(420);
  endtask

  task automatic test_receiver_bursty();
    send_idle_pct = 50;
    recv_idle_pct = 34;
    send_random_groups(420);
  endtask

  // Hold the output long enough to fill the pipeline, then pause the input to drain
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_random_groups(30);
    wait_for_results();
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_groups(420);
  endtask

  // Output stall: random holds plus long hold-offs on request
  initial begin : stall_gen
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare each output transfer with the oldest expected pixel pair
  always @(posedge clk) begin : check_results
    rgb_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result at %0t: %h", $realtime, out_data);
        end
      end else begin
        want = pending_rgb.pop_front();
        compare_field("red_first",     want.red_first,     out_data.red_first);
        compare_field("green_first",   want.green_first,   out_data.green_first);
        compare_field("blue_first",    want.blue_first,    out_data.blue_first);
        compare_field("red_second",    want.red_second,    out_data.red_second);
        compare_field("green_second",  want.green_second,  out_data.green_second);
        compare_field("blue_second",   want.blue_second,   out_data.blue_second);
        compare_field("frame_end_out", 8'(want.frame_end_out), 8'(out_data.frame_end_out));
      end
    end
  end

  // Cycle watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_sender_bursty();
    test_receiver_bursty();
    test_output_holdoff();
    test_full_rate();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
